// ===== rtl/cnmt_pkg.sv =====
// Shared types and constants for the cosine nearest-match table.
`default_nettype none
package cnmt_pkg;

	localparam int LEN_W = 8;
	localparam int ID_W = 32;
	localparam int EL_W = 16;
	localparam int ACC_W = 40;
	localparam int HALF_W = 20;
	localparam int PROD_W = 80;
	localparam int QUO_W = 31;
	localparam int ROOT_W = 16;
	localparam int CNT_OUT_W = 7;
	localparam int LIMIT_W = 7;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_USER_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		OP_ENROLL = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_DISABLED  = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  user_id;
		logic [EL_W-1:0]  element;
		logic             last;
		logic             wr;
		logic [LEN_W-1:0] pos;
		logic [LEN_W-1:0] len;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic                 match_valid;
		logic [ID_W-1:0]      match_id;
		logic [EL_W-1:0]      similarity;
		logic [CNT_OUT_W-1:0] user_count;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SR_WAIT,
		BK_SR_LEN,
		BK_SR_MAC,
		BK_SR_SCORE,
		BK_RM_WAIT,
		BK_RM_CHK,
		BK_RM_COPY
	} back_state_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_MUL,
		SC_DIV,
		SC_SQRT,
		SC_DONE
	} score_state_t;

endpackage
`default_nettype wire

// ===== rtl/cnmt_front.sv =====
// Front end: accepts requests, tracks the element stream and builds commands.
`default_nettype none
module cnmt_front #(
	parameter int VECTOR_LEN = 128
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  cnmt_pkg::op_t          in_op,
	input  wire [31:0]             in_id,
	input  wire [15:0]             in_elem,
	input  wire                    in_last,
	output logic                   cmd_valid,
	input  wire                    cmd_ready,
	output cnmt_pkg::cmd_t         cmd
);
	import cnmt_pkg::*;

	logic [LEN_W-1:0] cnt_q;
	logic             kind_q;
	logic             is_el;
	logic             restart;
	logic [LEN_W-1:0] cnt_eff;
	logic             wr;
	logic [LEN_W-1:0] cnt_nx;
	logic             accept;

	always_comb begin
		is_el = (in_op == OP_ENROLL) || (in_op == OP_SEARCH);
		restart = (cnt_q != '0) && (kind_q != (in_op == OP_SEARCH));
		cnt_eff = restart ? '0 : cnt_q;
		wr = cnt_eff < LEN_W'(VECTOR_LEN);
		cnt_nx = cnt_eff + LEN_W'(wr);
		accept = in_valid && cmd_ready;
		in_ready = cmd_ready;
		cmd_valid = in_valid;
		cmd.op = in_op;
		cmd.user_id = in_id;
		cmd.element = in_elem;
		cmd.last = in_last;
		cmd.wr = wr;
		cmd.pos = cnt_eff;
		cmd.len = cnt_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			kind_q <= 1'b0;
		end else if (accept) begin
			if (is_el) begin
				kind_q <= (in_op == OP_SEARCH);
				cnt_q <= in_last ? '0 : cnt_nx;
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cnmt_fifo.sv =====
// Two-entry command queue between front and back.
`default_nettype none
module cnmt_fifo (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  cnmt_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  wire            out_ready,
	output cnmt_pkg::cmd_t out_cmd
);
	import cnmt_pkg::*;

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	always_comb begin
		in_ready = cnt_q != 2'd2;
		out_valid = cnt_q != 2'd0;
		out_cmd = mem_q[rptr_q];
		push = in_valid && in_ready;
		pop = out_valid && out_ready;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cnmt_score.sv =====
// Cosine score unit: split multiplier, restoring divider and bitwise square root.
`default_nettype none
module cnmt_score (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire signed [39:0] dot,
	input  wire        [39:0] na,
	input  wire        [39:0] nb,
	output logic              done,
	output logic signed [15:0] value
);
	import cnmt_pkg::*;

	score_state_t state_q, state_nx;

	logic                 neg_q;
	logic [ACC_W-1:0]     mag_q;
	logic                 phase_q;
	logic [2:0]           mcnt_q;
	logic [ACC_W-1:0]     pp_s1;
	logic [1:0]           ppk_s1;
	logic [PROD_W-1:0]    acc_q;
	logic [PROD_W-1:0]    p_q;
	logic [PROD_W:0]      rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [4:0]           dcnt_q;
	logic [ROOT_W-1:0]    x_q;
	logic [3:0]           bcnt_q;
	logic signed [15:0]   res_q;

	logic                 zero;
	logic [ACC_W-1:0]     ma, mb;
	logic [HALF_W-1:0]    asel, bsel;
	logic [PROD_W-1:0]    ppsh;
	logic [PROD_W-1:0]    sum;
	logic [PROD_W:0]      dt;
	logic                 ge;
	logic [ROOT_W-1:0]    tc;
	logic [2*ROOT_W-1:0]  sq;
	logic [ROOT_W-1:0]    xn;

	always_comb begin
		zero = (na == '0) || (nb == '0);
		ma = phase_q ? mag_q : na;
		mb = phase_q ? mag_q : nb;
		asel = mcnt_q[1] ? ma[ACC_W-1:HALF_W] : ma[HALF_W-1:0];
		bsel = mcnt_q[0] ? mb[ACC_W-1:HALF_W] : mb[HALF_W-1:0];
		case (ppk_s1)
			2'd0:           ppsh = PROD_W'(pp_s1);
			2'd1, 2'd2:     ppsh = PROD_W'(pp_s1) << HALF_W;
			default:        ppsh = PROD_W'(pp_s1) << (2 * HALF_W);
		endcase
		sum = acc_q + ppsh;
		dt = (dcnt_q == '0) ? rem_q : {rem_q[PROD_W-1:0], 1'b0};
		ge = dt >= {1'b0, p_q};
		tc = x_q | (ROOT_W'(1) << bcnt_q);
		sq = tc * tc;
		xn = (sq <= (2*ROOT_W)'(quo_q)) ? tc : x_q;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			SC_IDLE: if (start) begin
				state_nx = zero ? SC_DONE : SC_MUL;
			end
			SC_MUL: if (mcnt_q == 3'd4 && phase_q) begin
				state_nx = SC_DIV;
			end
			SC_DIV: if (dcnt_q == 5'(QUO_W - 1)) begin
				state_nx = SC_SQRT;
			end
			SC_SQRT: if (bcnt_q == '0) begin
				state_nx = SC_DONE;
			end
			SC_DONE: state_nx = SC_IDLE;
			default: state_nx = SC_IDLE;
		endcase
	end

	always_comb begin
		done = state_q == SC_DONE;
		value = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: if (start) begin
				neg_q <= dot[ACC_W-1];
				mag_q <= dot[ACC_W-1] ? ACC_W'(-dot) : ACC_W'(dot);
				phase_q <= 1'b0;
				mcnt_q <= '0;
				acc_q <= '0;
				res_q <= '0;
			end
			SC_MUL: begin
				if (mcnt_q < 3'd4) begin
					pp_s1 <= asel * bsel;
					ppk_s1 <= mcnt_q[1:0];
				end
				if (mcnt_q == 3'd4) begin
					mcnt_q <= '0;
					acc_q <= '0;
					if (!phase_q) begin
						p_q <= sum;
						phase_q <= 1'b1;
					end else begin
						rem_q <= {1'b0, sum};
						quo_q <= '0;
						dcnt_q <= '0;
					end
				end else begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q != '0) begin
						acc_q <= sum;
					end
				end
			end
			SC_DIV: begin
				rem_q <= ge ? dt - {1'b0, p_q} : dt;
				quo_q <= {quo_q[QUO_W-2:0], ge};
				dcnt_q <= dcnt_q + 5'd1;
				x_q <= '0;
				bcnt_q <= 4'(ROOT_W - 1);
			end
			SC_SQRT: begin
				x_q <= xn;
				bcnt_q <= bcnt_q - 4'd1;
				if (bcnt_q == '0) begin
					if (neg_q) begin
						res_q <= 16'(-{1'b0, xn});
					end else begin
						res_q <= xn[ROOT_W-1] ? 16'sh7FFF : $signed(xn);
					end
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/cnmt_back.sv =====
// Back end: entry table, vector memories, search sequencer and removal compaction.
`default_nettype none
module cnmt_back #(
	parameter int MAX_ENTRIES = 64,
	parameter int VECTOR_LEN  = 128
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_ready,
	input  cnmt_pkg::cmd_t     cmd,
	input  wire                enable,
	input  wire [6:0]          user_limit,
	output logic               out_valid,
	input  wire                out_ready,
	output cnmt_pkg::result_t  out_res
);
	import cnmt_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int IDX_W = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
	localparam int VS_AW = SLOT_W + IDX_W;
	localparam int VS_DEPTH = MAX_ENTRIES * (2 ** IDX_W);
	localparam int LW = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	back_state_t state_q, state_nx;

	logic [EL_W-1:0]  vstore_mem [VS_DEPTH];
	logic [EL_W-1:0]  qbuf_mem [VECTOR_LEN];
	logic [ID_W-1:0]  ids_mem [MAX_ENTRIES];
	logic [LEN_W-1:0] lens_mem [MAX_ENTRIES];

	logic signed [EL_W-1:0] v_rd_q;
	logic signed [EL_W-1:0] q_rd_q;
	logic [ID_W-1:0]        ids_rd_q;
	logic [LEN_W-1:0]       lens_rd_q;

	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       slot_q;
	logic [CNT_W-1:0]       keep_q;
	logic [ID_W-1:0]        rm_id_q;
	logic [LEN_W-1:0]       qlen_q;
	logic [LEN_W-1:0]       n_q;
	logic [LEN_W-1:0]       i_q;
	logic                   v1_s1;
	logic                   v2_s2;
	logic                   cv_s1;
	logic [IDX_W-1:0]       cidx_s1;
	logic signed [31:0]     pd_s2, pa_s2, pb_s2;
	logic signed [ACC_W-1:0] dot_q;
	logic [ACC_W-1:0]       na_q, nb_q;
	logic signed [EL_W-1:0] best_q;
	logic                   mvalid_q;
	logic [ID_W-1:0]        mid_q;
	logic [ID_W-1:0]        cand_id_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic                   sc_start;
	logic                   sc_done;
	logic signed [EL_W-1:0] sc_val;

	logic                   needs_res, out_free, pop;
	logic [LW-1:0]          lim;
	logic                   en_full;
	logic                   mac_done, copy_done, last_slot;
	logic                   upd, nvalid;
	logic signed [EL_W-1:0] nbest;
	logic [ID_W-1:0]        nid;
	logic                   rm_match, rm_copy, rm_next;
	logic [CNT_W-1:0]       keep_nx;

	logic                   vs_we;
	logic [VS_AW-1:0]       vs_wa;
	logic [EL_W-1:0]        vs_wd;
	logic                   qb_we;
	logic                   id_we;
	logic [SLOT_W-1:0]      id_wa;
	logic [ID_W-1:0]        id_wd;
	logic [LEN_W-1:0]       ln_wd;
	logic                   out_load;
	result_t                res;

	cnmt_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.dot    (dot_q),
		.na     (na_q),
		.nb     (nb_q),
		.done   (sc_done),
		.value  (sc_val)
	);

	always_comb begin
		needs_res = cmd.last || (cmd.op == OP_REMOVE) || (cmd.op == OP_CLEAR);
		out_free = !out_valid_q || out_ready;
		pop = (state_q == BK_IDLE) && cmd_valid && (!needs_res || out_free);
		lim = (LW'(user_limit) >= LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(user_limit);
		en_full = LW'(count_q) >= lim;
		mac_done = (i_q == n_q) && !v1_s1 && !v2_s2;
		copy_done = (i_q == LEN_W'(VECTOR_LEN)) && !cv_s1;
		last_slot = (slot_q + CNT_W'(1)) == count_q;
		upd = sc_val > best_q;
		nvalid = mvalid_q || upd;
		nbest = upd ? sc_val : best_q;
		nid = upd ? cand_id_q : mid_q;
		rm_match = ids_rd_q == rm_id_q;
		rm_copy = (state_q == BK_RM_CHK) && !rm_match && (keep_q != slot_q);
		rm_next = ((state_q == BK_RM_CHK) && !rm_copy) || ((state_q == BK_RM_COPY) && copy_done);
		keep_nx = keep_q + CNT_W'(!rm_match);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: if (pop) begin
				if (cmd.op == OP_SEARCH && cmd.last && enable && count_q != '0) begin
					state_nx = BK_SR_WAIT;
				end else if (cmd.op == OP_REMOVE && count_q != '0) begin
					state_nx = BK_RM_WAIT;
				end
			end
			BK_SR_WAIT: state_nx = BK_SR_LEN;
			BK_SR_LEN: state_nx = BK_SR_MAC;
			BK_SR_MAC: if (mac_done) begin
				state_nx = BK_SR_SCORE;
			end
			BK_SR_SCORE: if (sc_done) begin
				state_nx = last_slot ? BK_IDLE : BK_SR_WAIT;
			end
			BK_RM_WAIT: state_nx = BK_RM_CHK;
			BK_RM_CHK: begin
				if (rm_copy) begin
					state_nx = BK_RM_COPY;
				end else begin
					state_nx = last_slot ? BK_IDLE : BK_RM_WAIT;
				end
			end
			BK_RM_COPY: if (copy_done) begin
				state_nx = last_slot ? BK_IDLE : BK_RM_WAIT;
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = pop;
		vs_we = 1'b0;
		vs_wa = {count_q[SLOT_W-1:0], cmd.pos[IDX_W-1:0]};
		vs_wd = cmd.element;
		qb_we = 1'b0;
		id_we = 1'b0;
		id_wa = count_q[SLOT_W-1:0];
		id_wd = cmd.user_id;
		ln_wd = cmd.len;
		out_load = 1'b0;
		sc_start = 1'b0;
		res = '0;
		res.status = ST_OK;
		res.user_count = CNT_OUT_W'(count_q);
		unique case (state_q)
			BK_IDLE: if (pop) begin
				case (cmd.op)
					OP_ENROLL: begin
						vs_we = cmd.wr && (count_q < CNT_W'(MAX_ENTRIES));
						if (cmd.last) begin
							out_load = 1'b1;
							if (!enable) begin
								res.status = ST_DISABLED;
							end else if (en_full) begin
								res.status = ST_FULL;
							end else begin
								id_we = 1'b1;
								res.user_count = CNT_OUT_W'(count_q + CNT_W'(1));
							end
						end
					end
					OP_SEARCH: begin
						qb_we = cmd.wr;
						if (cmd.last && !enable) begin
							out_load = 1'b1;
							res.status = ST_DISABLED;
						end else if (cmd.last && count_q == '0) begin
							out_load = 1'b1;
						end
					end
					OP_REMOVE: if (count_q == '0) begin
						out_load = 1'b1;
						res.status = ST_NOT_FOUND;
					end
					default: begin
						out_load = 1'b1;
						res.user_count = '0;
					end
				endcase
			end
			BK_SR_MAC: sc_start = mac_done;
			BK_SR_SCORE: if (sc_done && last_slot) begin
				out_load = 1'b1;
				res.match_valid = nvalid;
				res.match_id = nvalid ? nid : '0;
				res.similarity = nvalid ? nbest : '0;
			end
			BK_RM_CHK: if (rm_copy) begin
				id_we = 1'b1;
				id_wa = keep_q[SLOT_W-1:0];
				id_wd = ids_rd_q;
				ln_wd = lens_rd_q;
			end
			BK_RM_COPY: begin
				vs_we = cv_s1;
				vs_wa = {keep_q[SLOT_W-1:0], cidx_s1};
				vs_wd = v_rd_q;
			end
			default: ;
		endcase
		if (rm_next && last_slot) begin
			out_load = 1'b1;
			res.status = (keep_nx == count_q) ? ST_NOT_FOUND : ST_OK;
			res.user_count = CNT_OUT_W'(keep_nx);
		end
	end

	always_comb begin
		out_valid = out_valid_q;
		out_res = out_q;
	end

	always_ff @(posedge clk) begin
		v_rd_q <= vstore_mem[{slot_q[SLOT_W-1:0], i_q[IDX_W-1:0]}];
		q_rd_q <= qbuf_mem[i_q[IDX_W-1:0]];
		ids_rd_q <= ids_mem[slot_q[SLOT_W-1:0]];
		lens_rd_q <= lens_mem[slot_q[SLOT_W-1:0]];
		if (vs_we) begin
			vstore_mem[vs_wa] <= vs_wd;
		end
		if (qb_we) begin
			qbuf_mem[cmd.pos[IDX_W-1:0]] <= cmd.element;
		end
		if (id_we) begin
			ids_mem[id_wa] <= id_wd;
			lens_mem[id_wa] <= ln_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			cv_s1 <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && cmd.op == OP_ENROLL && cmd.last && enable && !en_full) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && cmd.op == OP_CLEAR) begin
				count_q <= '0;
			end else if (rm_next && last_slot) begin
				count_q <= keep_nx;
			end
			v1_s1 <= (state_q == BK_SR_MAC) && (i_q < n_q);
			v2_s2 <= v1_s1;
			cv_s1 <= (state_q == BK_RM_COPY) && (i_q < LEN_W'(VECTOR_LEN));
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
		pd_s2 <= q_rd_q * v_rd_q;
		pa_s2 <= q_rd_q * q_rd_q;
		pb_s2 <= v_rd_q * v_rd_q;
		case (state_q)
			BK_IDLE: if (pop) begin
				qlen_q <= cmd.len;
				slot_q <= '0;
				keep_q <= '0;
				rm_id_q <= cmd.user_id;
				best_q <= 16'sh8000;
				mvalid_q <= 1'b0;
				mid_q <= '0;
			end
			BK_SR_LEN: begin
				n_q <= (lens_rd_q < qlen_q) ? lens_rd_q : qlen_q;
				cand_id_q <= ids_rd_q;
				i_q <= '0;
				dot_q <= '0;
				na_q <= '0;
				nb_q <= '0;
			end
			BK_SR_MAC: begin
				if (i_q < n_q) begin
					i_q <= i_q + LEN_W'(1);
				end
				if (v2_s2) begin
					dot_q <= dot_q + ACC_W'(pd_s2);
					na_q <= na_q + ACC_W'(pa_s2);
					nb_q <= nb_q + ACC_W'(pb_s2);
				end
			end
			BK_SR_SCORE: if (sc_done) begin
				best_q <= nbest;
				mvalid_q <= nvalid;
				mid_q <= nid;
				slot_q <= slot_q + CNT_W'(1);
			end
			BK_RM_CHK: begin
				i_q <= '0;
				if (rm_next) begin
					keep_q <= keep_nx;
					slot_q <= slot_q + CNT_W'(1);
				end
			end
			BK_RM_COPY: begin
				if (i_q < LEN_W'(VECTOR_LEN)) begin
					i_q <= i_q + LEN_W'(1);
				end
				cidx_s1 <= i_q[IDX_W-1:0];
				if (copy_done) begin
					keep_q <= keep_nx;
					slot_q <= slot_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/cosine_nearest_match_table_top.sv =====
// Top level of the cosine nearest-match table: stream ports, registers, front, queue, back.
// Element, enroll and clear requests are handled in the idle state of the back end; the result
// passes the command queue and the result register. A search scores each entry: two table reads,
// a MAC pass over n elements, n the shorter length, then multiply, divide, square root and done.
// A remove checks each entry and copies every moved entry element by element (one memory port).
// Reset empties the table, disables the block and sets the limit to 64; memories are not cleared.
`default_nettype none
module cosine_nearest_match_table_top #(
	parameter int MAX_ENTRIES = 64,
	parameter int VECTOR_LEN  = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [47:0] s_axis_tdata,   // user_id[31:0], element[47:32]
	input  wire  [1:0]  s_axis_tuser,   // op[1:0]
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata,   // status, match_valid, match_id, similarity, user_count
	input  wire         cfg_we,
	input  wire         cfg_addr,
	input  wire  [6:0]  cfg_wdata
);
	import cnmt_pkg::*;

	logic                 enable_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic                 f_valid, f_ready;
	cmd_t                 f_cmd;
	logic                 b_valid, b_ready;
	cmd_t                 b_cmd;
	result_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			limit_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ENABLE:     enable_q <= cfg_wdata[0];
				REG_USER_LIMIT: limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	cnmt_front #(.VECTOR_LEN(VECTOR_LEN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (op_t'(s_axis_tuser)),
		.in_id     (s_axis_tdata[31:0]),
		.in_elem   (s_axis_tdata[47:32]),
		.in_last   (s_axis_tlast),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	cnmt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_cmd   (b_cmd)
	);

	cnmt_back #(.MAX_ENTRIES(MAX_ENTRIES), .VECTOR_LEN(VECTOR_LEN)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (b_valid),
		.cmd_ready  (b_ready),
		.cmd        (b_cmd),
		.enable     (enable_q),
		.user_limit (limit_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	always_comb begin
		m_axis_tdata = {6'd0, res.user_count, res.similarity, res.match_id,
			res.match_valid, res.status};
	end

endmodule
`default_nettype wire
